@@ rtl/ptrt_pkg.sv @@
// Shared constants and types for the periodic tick routine table.
package ptrt_pkg;

	localparam int SLOTS  = 8;
	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int ID_W   = 8;
	localparam int PER_W  = 16;
	localparam int TICK_W = 32;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_ADD  = 2'd1;
	localparam logic [1:0] OP_DEL  = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0]  routine;
		logic [PER_W-1:0] period;
		logic [PER_W-1:0] counter;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef struct packed {
		logic report;
		logic match;
	} alu_flags_t;

endpackage

@@ rtl/ptrt_ram.sv @@
// Generic single write port RAM with registered read.
module ptrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/ptrt_slot_alu.sv @@
// Shared slot unit: counter decrement or reload, fire detect and id compare.
module ptrt_slot_alu (
	input  ptrt_pkg::slot_t                slot,
	input  logic [ptrt_pkg::ID_W-1:0]      key,
	output ptrt_pkg::slot_t                next_slot,
	output ptrt_pkg::alu_flags_t           flags
);
	import ptrt_pkg::*;

	logic expired;

	assign expired = (slot.counter == '0);

	always_comb begin
		next_slot         = slot;
		next_slot.counter = expired ? slot.period : slot.counter - PER_W'(1);
	end

	assign flags.report = expired && (slot.routine != '0);
	assign flags.match  = (slot.routine == key);

endmodule

@@ rtl/periodic_tick_routine_table.sv @@
// Top level: periodic tick routine table with sequencer and output register.
//
//  channel | direction | handshake          | contents
//  s       | in        | s_tvalid/s_tready  | tdata: op, routine_id, period; tuser: single_step
//  m       | out       | m_tvalid/m_tready  | tdata: fired_id, done_ok, tick_count; tuser: fired
//  cfg     | in        | cfg_we             | cfg_wdata: run_enable
//
// Add writes its slot while idle. Delete and advancing tick visit each stored slot
// in a read then an execute state, set by the single slot RAM read port feeding
// the shared slot unit. Reset clears the slot count and tick count and sets run_enable
// to 1; slot contents stay unknown until written. No word is taken while a word is
// in progress; a stalled output register holds the sequencer before its next emit.
module periodic_tick_routine_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [1:0] op, [9:2] routine_id, [25:10] period
	input  logic        s_tuser,   // [0] single_step
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] fired_id, [8] done_ok, [40:9] tick_count
	output logic        m_tuser,   // [0] fired
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_wdata  // run_enable
);
	import ptrt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD   = 4'b0010,
		S_EXE  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [1:0]          op_q;
	logic [ID_W-1:0]     id_q;
	logic                run_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TICK_W-1:0]   tick_q;
	logic [IDX_W-1:0]    idx_q;
	logic                found_q;
	logic                ok_q;
	logic                pend_v_q;
	logic [ID_W-1:0]     pend_id_q;

	logic                m_valid_q;
	logic [ID_W-1:0]     out_id_q;
	logic                out_fired_q;
	logic                out_ok_q;
	logic                out_last_q;
	logic [TICK_W-1:0]   out_tick_q;

	logic [1:0]          in_op;
	logic [ID_W-1:0]     in_id;
	logic [PER_W-1:0]    in_per;

	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	slot_t               ram_wdata;
	slot_t               ram_rdata;
	slot_t               alu_next;
	alu_flags_t          alu_flags;

	logic                out_free;
	logic                is_last;
	logic                exe_stall;
	logic                emit;
	logic [ID_W-1:0]     emit_id;
	logic                emit_fired;
	logic                emit_ok;
	logic                emit_last;

	assign in_op  = s_tdata[1:0];
	assign in_id  = s_tdata[9:2];
	assign in_per = s_tdata[25:10];

	assign out_free = !m_valid_q || m_tready;
	assign is_last  = (CNT_W'(idx_q) == (cnt_q - CNT_W'(1)));
	assign s_tready = (state_q == S_IDLE);

	ptrt_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	ptrt_slot_alu u_alu (
		.slot      (ram_rdata),
		.key       (id_q),
		.next_slot (alu_next),
		.flags     (alu_flags)
	);

	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = idx_q;
		ram_wdata  = ram_rdata;
		exe_stall  = 1'b0;
		emit       = 1'b0;
		emit_id    = '0;
		emit_fired = 1'b0;
		emit_ok    = 1'b0;
		emit_last  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid && in_op == OP_ADD && cnt_q < CNT_W'(SLOTS)) begin
					ram_we    = 1'b1;
					ram_waddr = IDX_W'(cnt_q);
					ram_wdata = '{routine: in_id, period: in_per, counter: in_per};
				end
			end
			S_EXE: begin
				if (op_q == OP_TICK) begin
					exe_stall = alu_flags.report && pend_v_q && !out_free;
					if (!exe_stall) begin
						ram_we    = 1'b1;
						ram_wdata = alu_next;
						// previous fire is not the final one
						emit       = alu_flags.report && pend_v_q;
						emit_id    = pend_id_q;
						emit_fired = 1'b1;
						emit_ok    = 1'b1;
					end
				end else if (found_q) begin
					ram_we    = 1'b1;
					ram_waddr = idx_q - IDX_W'(1);
				end
			end
			S_FIN: begin
				if (out_free) begin
					emit       = 1'b1;
					emit_id    = pend_v_q ? pend_id_q : '0;
					emit_fired = pend_v_q;
					emit_ok    = ok_q;
					emit_last  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_TICK;
			run_q     <= 1'b1;
			cnt_q     <= '0;
			tick_q    <= '0;
			idx_q     <= '0;
			found_q   <= 1'b0;
			ok_q      <= 1'b0;
			pend_v_q  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				run_q <= cfg_wdata;
			end
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q     <= in_op;
						idx_q    <= '0;
						found_q  <= 1'b0;
						pend_v_q <= 1'b0;
						ok_q     <= 1'b0;
						state_q  <= S_FIN;
						case (in_op)
							OP_ADD: begin
								if (cnt_q < CNT_W'(SLOTS)) begin
									cnt_q <= cnt_q + CNT_W'(1);
									ok_q  <= 1'b1;
								end
							end
							OP_DEL: begin
								if (cnt_q != '0) begin
									state_q <= S_RD;
								end
							end
							OP_TICK: begin
								if (run_q || s_tuser) begin
									tick_q <= tick_q + TICK_W'(1);
									ok_q   <= 1'b1;
									if (cnt_q != '0) begin
										state_q <= S_RD;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_EXE;
				end
				S_EXE: begin
					if (!exe_stall) begin
						if (op_q == OP_TICK) begin
							if (alu_flags.report) begin
								pend_v_q  <= 1'b1;
								pend_id_q <= ram_rdata.routine;
							end
						end else if (!found_q && alu_flags.match) begin
							found_q <= 1'b1;
							ok_q    <= 1'b1;
						end
						if (is_last) begin
							if (op_q == OP_DEL && (found_q || alu_flags.match)) begin
								cnt_q <= cnt_q - CNT_W'(1);
							end
							state_q <= S_FIN;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= S_RD;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			id_q <= in_id;
		end
		if (emit) begin
			out_id_q    <= emit_id;
			out_fired_q <= emit_fired;
			out_ok_q    <= emit_ok;
			out_last_q  <= emit_last;
			out_tick_q  <= tick_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, out_tick_q, out_ok_q, out_id_q};
	assign m_tuser  = out_fired_q;
	assign m_tlast  = out_last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(SLOTS))
		else $error("slot count beyond table size");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_EXE) |-> (CNT_W'(idx_q) < cnt_q))
		else $error("slot index past filled entries");

	a_pend_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (op_q == OP_TICK))
		else $error("pending fire outside a tick");

	a_fin_emits_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> (m_tvalid && m_tlast && state_q == S_IDLE))
		else $error("final word not issued on leaving finish");

	a_tick_moves_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> $stable(tick_q))
		else $error("tick count changed mid word");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the periodic tick routine table: directed table, then random words.
module tb;
	import ptrt_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic [7:0]  id;
		logic        fired;
		logic        ok;
		logic        last;
		logic [31:0] ticks;
	} report_t;

	typedef struct packed {
		logic        set_run;
		logic        run_val;
		logic [1:0]  op;
		logic [7:0]  id;
		logic [15:0] per;
		logic        step;
		logic        typed;
		logic        ok;
		logic [31:0] ticks;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;

	// predicted table state
	logic [7:0]  tbl_id [SLOTS];
	logic [15:0] tbl_per [SLOTS];
	logic [16:0] tbl_cnt [SLOTS];
	int          tbl_n = 0;
	logic [31:0] tick_total = '0;
	logic        run_en = 1'b1;

	report_t     step_reports [$];
	report_t     reports_due [$];
	int          mismatches = 0;
	int          words_out = 0;

	periodic_tick_routine_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	function automatic void table_step(input logic [1:0] op, input logic [7:0] id,
			input logic [15:0] per, input logic step);
		int i;
		int hit;
		step_reports.delete();
		case (op)
			OP_ADD: begin
				if (tbl_n < SLOTS) begin
					tbl_id[tbl_n]  = id;
					tbl_per[tbl_n] = per;
					tbl_cnt[tbl_n] = {1'b0, per};
					tbl_n++;
					step_reports.push_back(report_t'{8'h00, 1'b0, 1'b1, 1'b1, tick_total});
				end else begin
					step_reports.push_back(report_t'{8'h00, 1'b0, 1'b0, 1'b1, tick_total});
				end
			end
			OP_DEL: begin
				hit = -1;
				for (i = 0; i < tbl_n; i++)
					if (hit < 0 && tbl_id[i] == id)
						hit = i;
				if (hit >= 0) begin
					for (i = hit; i < tbl_n - 1; i++) begin
						tbl_id[i]  = tbl_id[i + 1];
						tbl_per[i] = tbl_per[i + 1];
						tbl_cnt[i] = tbl_cnt[i + 1];
					end
					tbl_n--;
				end
				step_reports.push_back(report_t'{8'h00, 1'b0, hit >= 0, 1'b1, tick_total});
			end
			OP_TICK: begin
				if (run_en || step) begin
					tick_total++;
					for (i = 0; i < tbl_n; i++) begin
						if (tbl_cnt[i] == 0) begin
							tbl_cnt[i] = {1'b0, tbl_per[i]};
							if (tbl_id[i] != 8'h00)
								step_reports.push_back(report_t'{tbl_id[i], 1'b1, 1'b1,
									1'b0, tick_total});
						end else begin
							tbl_cnt[i] = tbl_cnt[i] - 1'b1;
						end
					end
					if (step_reports.size() == 0)
						step_reports.push_back(report_t'{8'h00, 1'b0, 1'b1, 1'b1, tick_total});
					else
						step_reports[step_reports.size() - 1].last = 1'b1;
				end else begin
					step_reports.push_back(report_t'{8'h00, 1'b0, 1'b0, 1'b1, tick_total});
				end
			end
			default: begin
				step_reports.push_back(report_t'{8'h00, 1'b0, 1'b0, 1'b1, tick_total});
			end
		endcase
	endfunction

	task automatic offer_word(input logic [1:0] op, input logic [7:0] id, input logic [15:0] per,
			input logic step, input bit calm, input bit typed, input logic ok,
			input logic [31:0] ticks);
		while (!calm && $urandom_range(99) < 26) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, per, id, op};
		s_tuser  <= step;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		table_step(op, id, per, step);
		if (typed)
			reports_due.push_back(report_t'{8'h00, 1'b0, ok, 1'b1, ticks});
		else
			foreach (step_reports[k])
				reports_due.push_back(step_reports[k]);
	endtask

	// only once the table has gone quiet
	task automatic set_run(input logic v);
		s_tvalid <= 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		run_en = v;
	endtask

	initial begin
		row_t        plan [23];
		int          sent;
		logic [1:0]  op;
		logic [7:0]  id;
		logic [15:0] per;
		int          r;
		plan[0]  = '{1'b1, 1'b1, OP_TICK, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b1, 32'd1};
		plan[1]  = '{1'b0, 1'b0, OP_DEL,  8'h00, 16'h0000, 1'b0, 1'b1, 1'b0, 32'd1};
		plan[2]  = '{1'b0, 1'b0, OP_ADD,  8'hFF, 16'h0000, 1'b0, 1'b1, 1'b1, 32'd1};
		plan[3]  = '{1'b0, 1'b0, OP_ADD,  8'h00, 16'h0000, 1'b1, 1'b1, 1'b1, 32'd1};
		plan[4]  = '{1'b0, 1'b0, OP_ADD,  8'h01, 16'hFFFF, 1'b0, 1'b1, 1'b1, 32'd1};
		plan[5]  = '{1'b0, 1'b0, OP_ADD,  8'hAA, 16'h0001, 1'b0, 1'b0, 1'b0, 32'd0};
		plan[6]  = '{1'b0, 1'b0, OP_ADD,  8'h55, 16'h0002, 1'b1, 1'b0, 1'b0, 32'd0};
		plan[7]  = '{1'b0, 1'b0, OP_ADD,  8'h80, 16'h0003, 1'b0, 1'b0, 1'b0, 32'd0};
		plan[8]  = '{1'b0, 1'b0, OP_ADD,  8'h7F, 16'hAAAA, 1'b0, 1'b0, 1'b0, 32'd0};
		plan[9]  = '{1'b0, 1'b0, OP_ADD,  8'h01, 16'h5555, 1'b0, 1'b1, 1'b1, 32'd1};
		plan[10] = '{1'b0, 1'b0, OP_ADD,  8'h33, 16'h1234, 1'b0, 1'b1, 1'b0, 32'd1};
		plan[11] = '{1'b0, 1'b0, OP_TICK, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b0, 32'd0};
		plan[12] = '{1'b0, 1'b0, OP_TICK, 8'hFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 32'd0};
		plan[13] = '{1'b0, 1'b0, OP_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, 32'd0};
		plan[14] = '{1'b0, 1'b0, OP_DEL,  8'h99, 16'h0000, 1'b0, 1'b1, 1'b0, 32'd4};
		plan[15] = '{1'b0, 1'b0, OP_DEL,  8'h00, 16'h0000, 1'b0, 1'b1, 1'b1, 32'd4};
		plan[16] = '{1'b0, 1'b0, OP_DEL,  8'h01, 16'h0000, 1'b0, 1'b1, 1'b1, 32'd4};
		plan[17] = '{1'b0, 1'b0, OP_NONE, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 32'd4};
		plan[18] = '{1'b0, 1'b0, OP_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, 32'd0};
		plan[19] = '{1'b1, 1'b0, OP_TICK, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b0, 32'd5};
		plan[20] = '{1'b0, 1'b0, OP_TICK, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b0, 32'd0};
		plan[21] = '{1'b0, 1'b0, OP_ADD,  8'h42, 16'h0000, 1'b0, 1'b0, 1'b0, 32'd0};
		plan[22] = '{1'b0, 1'b0, OP_TICK, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b0, 32'd6};
		sent = 0;
		wait (arst_n);
		@(posedge clk);
		foreach (plan[i]) begin
			if (plan[i].set_run)
				set_run(plan[i].run_val);
			offer_word(plan[i].op, plan[i].id, plan[i].per, plan[i].step, 1'b0,
				plan[i].typed, plan[i].ok, plan[i].ticks);
			sent++;
		end
		for (int phase = 0; phase < 4; phase++) begin
			set_run(phase % 2 == 0);
			for (int n = 0; n < 88; n++) begin
				r = $urandom_range(99);
				if (r < 48)
					op = OP_TICK;
				else if (r < 73)
					op = OP_ADD;
				else if (r < 95)
					op = OP_DEL;
				else
					op = OP_NONE;
				if (op == OP_DEL && tbl_n > 0 && $urandom_range(99) < 75)
					id = tbl_id[$urandom_range(tbl_n - 1)];
				else if ($urandom_range(9) == 0)
					id = 8'h00;
				else if ($urandom_range(1) == 0)
					id = 8'($urandom_range(1, 12));
				else
					id = 8'($urandom_range(255));
				if ($urandom_range(9) == 0)
					per = 16'($urandom_range(65535));
				else
					per = 16'($urandom_range(6));
				offer_word(op, id, per, 1'($urandom_range(1)), sent >= 200 && sent < 260,
					1'b0, 1'b0, 32'd0);
				sent++;
			end
		end
		s_tvalid <= 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && reports_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// receiver: random stalls, one long hold-off, then a stall-free stretch
	initial begin
		bit held;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && words_out >= 150) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				m_tready <= (words_out >= 400 && words_out < 600) || ($urandom_range(99) >= 26);
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		report_t due;
		if (arst_n && m_tvalid && m_tready) begin
			words_out++;
			if (reports_due.size() == 0) begin
				report_mismatch("unexpected word", m_tdata[31:0], 32'd0);
			end else begin
				due = reports_due.pop_front();
				if (m_tdata[7:0] !== due.id)
					report_mismatch("fired_id", 32'(m_tdata[7:0]), 32'(due.id));
				if (m_tuser !== due.fired)
					report_mismatch("fired", 32'(m_tuser), 32'(due.fired));
				if (m_tdata[8] !== due.ok)
					report_mismatch("done_ok", 32'(m_tdata[8]), 32'(due.ok));
				if (m_tlast !== due.last)
					report_mismatch("last", 32'(m_tlast), 32'(due.last));
				if (m_tdata[40:9] !== due.ticks)
					report_mismatch("tick_count", m_tdata[40:9], due.ticks);
			end
		end
	end

endmodule
